>>> hdl/sme_pkg.sv
// Shared types and opcode/status codes for the stack-machine executor.
`timescale 1ns / 1ps
package sme_pkg;
    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_NEG  = 3'd5,
        OP_RET  = 3'd6,
        OP_NOP  = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_READ,
        EX_CALC,
        EX_MUL,
        EX_DIV,
        EX_DONE
    } ex_state_t;

    localparam int DEPTH_W = 9;
endpackage

>>> hdl/sme_if.sv
// Valid/ready channel interfaces for instruction and result words.
`timescale 1ns / 1ps
interface sme_in_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic [2:0]                    kind;
    logic signed [VALUE_WIDTH-1:0] constant_value;
    modport source (output valid, kind, constant_value, input ready);
    modport sink (input valid, kind, constant_value, output ready);
endinterface

interface sme_out_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] top_value;
    logic [8:0]                    depth;
    logic                          finished;
    logic [1:0]                    status;
    modport source (output valid, top_value, depth, finished, status, input ready);
    modport sink (input valid, top_value, depth, finished, status, output ready);
endinterface

>>> hdl/stack_machine_arith_executor.sv
// Top level: instruction front end, queue and stack execution back end.
// Each instruction runs on its own through the read, calculate and done states; multiply
// adds a multiply state and divide a divide state (one quotient bit per cycle).
// One instruction at a time: a new one starts only once the previous result word
// has been taken at the output; the 2-entry queue absorbs input.
// Reset empties the stack count and queue; stack memory is not cleared.
`timescale 1ns / 1ps
module stack_machine_arith_executor #(
    parameter int STACK_DEPTH = 256,
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input logic       clk,
    input logic       rst_n,
    sme_in_if.sink    in,
    sme_out_if.source out
);
    logic                   q_full, q_empty, q_pop;
    logic [2:0]             q_kind;
    logic [VALUE_WIDTH-1:0] q_value;

    assign in.ready = !q_full;

    sme_queue #(.VALUE_WIDTH(VALUE_WIDTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(in.valid), .push_kind(in.kind), .push_value(in.constant_value),
        .full(q_full), .pop(q_pop), .empty(q_empty),
        .head_kind(q_kind), .head_value(q_value)
    );

    sme_exec #(
        .STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)
    ) u_exec (
        .clk(clk), .rst_n(rst_n),
        .q_empty(q_empty), .q_kind(q_kind), .q_value(q_value), .q_pop(q_pop),
        .res(out)
    );
endmodule

>>> hdl/sme_queue.sv
// Two-entry instruction queue between front end and execution back end.
`timescale 1ns / 1ps
module sme_queue #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [2:0]             push_kind,
    input  logic [VALUE_WIDTH-1:0] push_value,
    output logic                   full,
    input  logic                   pop,
    output logic                   empty,
    output logic [2:0]             head_kind,
    output logic [VALUE_WIDTH-1:0] head_value
);
    logic [2:0]             kind_reg  [2];
    logic [VALUE_WIDTH-1:0] value_reg [2];
    logic                   wp_reg, rp_reg;
    logic [1:0]             cnt_reg;

    assign full       = (cnt_reg == 2'd2);
    assign empty      = (cnt_reg == 2'd0);
    assign head_kind  = kind_reg[rp_reg];
    assign head_value = value_reg[rp_reg];

    always_ff @(posedge clk) begin
        if (push && !full) begin
            kind_reg[wp_reg]  <= push_kind;
            value_reg[wp_reg] <= push_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else begin
            if (push && !full) wp_reg <= ~wp_reg;
            if (pop && !empty) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

    always_ff @(posedge clk) begin
        if (rst_n) begin
            assert (!(cnt_reg == 2'd2 && !(pop && !empty) && push) || full)
                else $error("queue push while full");
        end
    end
endmodule

>>> hdl/sme_exec.sv
// Execution back end: operand stack memory, ALU, multiplier and divider.
`timescale 1ns / 1ps
module sme_exec #(
    parameter int STACK_DEPTH = 256,
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  logic [2:0]             q_kind,
    input  logic [VALUE_WIDTH-1:0] q_value,
    output logic                   q_pop,
    sme_out_if.source              res
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int NW = VALUE_WIDTH + FRAC_BITS;
    localparam int IW = $clog2(NW + 1);
    localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_top, rd_sec;

    sme_pkg::ex_state_t     state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [2:0]             op_reg;
    logic [VALUE_WIDTH-1:0] cval_reg;
    logic                   we;
    logic [AW-1:0]          wa;
    logic [VALUE_WIDTH-1:0] wd;
    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] ma_reg, mb_reg;
    logic [PW-1:0]          prod_reg;
    logic [NW-1:0]          num_reg;
    logic [NW-1:0]          quo_reg;
    logic [VALUE_WIDTH:0]   rem_reg;
    logic [IW-1:0]          it_reg;
    logic                   ov_valid_reg;
    logic [VALUE_WIDTH-1:0] ov_top_reg;
    logic [8:0]             ov_depth_reg;
    logic                   ov_fin_reg;
    logic [1:0]             ov_st_reg;
    logic [VALUE_WIDTH-1:0] o_top;
    logic [8:0]             o_depth;
    logic                   o_fin;
    logic [1:0]             o_st;

    function automatic logic [VALUE_WIDTH-1:0] mag(input logic [VALUE_WIDTH-1:0] x);
        mag = x[VALUE_WIDTH-1] ? (~x + VALUE_WIDTH'(1)) : x;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] sgnsat(input logic n,
                                                      input logic [NW-1:0] m);
        logic big;
        big = (m > NW'(VMAX));
        if (!n) sgnsat = big ? VMAX : m[VALUE_WIDTH-1:0];
        else if (m > NW'(VMIN)) sgnsat = VMIN;
        else sgnsat = ~m[VALUE_WIDTH-1:0] + VALUE_WIDTH'(1);
    endfunction

    // registered reads of top and second entries
    always_ff @(posedge clk) begin
        rd_top <= mem[AW'(cnt_reg - CW'(1))];
        rd_sec <= mem[AW'(cnt_reg - CW'(2))];
        if (we) mem[wa] <= wd;
    end

    logic [VALUE_WIDTH-1:0] sum, dif;
    logic [VALUE_WIDTH:0]   rtry;
    logic [PW-1:0]          shp;
    assign sum  = rd_sec + rd_top;
    assign dif  = rd_sec - rd_top;
    assign rtry = {rem_reg[VALUE_WIDTH-1:0], num_reg[NW-1]};
    assign shp  = prod_reg >> FRAC_BITS;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        we = 1'b0;
        wa = AW'(cnt_reg - CW'(1));
        wd = '0;
        q_pop = 1'b0;
        o_top = rd_top; o_depth = 9'(cnt_reg); o_fin = 1'b0;
        o_st = sme_pkg::ST_OK;
        case (state_reg)
            sme_pkg::EX_IDLE: begin
                if (!q_empty && !ov_valid_reg) begin
                    q_pop = 1'b1;
                    state_next = sme_pkg::EX_READ;
                end
            end
            sme_pkg::EX_READ: state_next = sme_pkg::EX_CALC;
            sme_pkg::EX_CALC: begin
                state_next = sme_pkg::EX_DONE;
                case (sme_pkg::opcode_t'(op_reg))
                    sme_pkg::OP_PUSH: begin
                        if (cnt_reg == CW'(STACK_DEPTH)) o_st = sme_pkg::ST_OVERFLOW;
                        else begin
                            we = 1'b1; wa = AW'(cnt_reg); wd = cval_reg;
                            cnt_next = cnt_reg + CW'(1); o_top = cval_reg;
                        end
                    end
                    sme_pkg::OP_ADD, sme_pkg::OP_SUB: begin
                        if (cnt_reg < CW'(2)) o_st = sme_pkg::ST_UNDERFLOW;
                        else begin
                            if (op_reg == sme_pkg::OP_ADD)
                                wd = (rd_sec[VALUE_WIDTH-1] == rd_top[VALUE_WIDTH-1] &&
                                      sum[VALUE_WIDTH-1] != rd_sec[VALUE_WIDTH-1]) ?
                                     (rd_sec[VALUE_WIDTH-1] ? VMIN : VMAX) : sum;
                            else
                                wd = (rd_sec[VALUE_WIDTH-1] != rd_top[VALUE_WIDTH-1] &&
                                      dif[VALUE_WIDTH-1] != rd_sec[VALUE_WIDTH-1]) ?
                                     (rd_sec[VALUE_WIDTH-1] ? VMIN : VMAX) : dif;
                            we = 1'b1; wa = AW'(cnt_reg - CW'(2));
                            cnt_next = cnt_reg - CW'(1); o_top = wd;
                        end
                    end
                    sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
                        if (cnt_reg < CW'(2)) o_st = sme_pkg::ST_UNDERFLOW;
                        else if (op_reg == sme_pkg::OP_DIV && rd_top == '0) begin
                            wd = rd_sec[VALUE_WIDTH-1] ? VMIN : VMAX;
                            we = 1'b1; wa = AW'(cnt_reg - CW'(2));
                            cnt_next = cnt_reg - CW'(1); o_top = wd;
                            o_st = sme_pkg::ST_DIVZERO;
                        end
                        else state_next = (op_reg == sme_pkg::OP_MUL) ?
                                          sme_pkg::EX_MUL : sme_pkg::EX_DIV;
                    end
                    sme_pkg::OP_NEG: begin
                        if (cnt_reg == '0) o_st = sme_pkg::ST_UNDERFLOW;
                        else begin
                            wd = (rd_top == VMIN) ? VMAX : (~rd_top + VALUE_WIDTH'(1));
                            we = 1'b1; o_top = wd;
                        end
                    end
                    sme_pkg::OP_RET: begin
                        o_fin = 1'b1;
                        if (cnt_reg == '0) o_st = sme_pkg::ST_UNDERFLOW;
                        else begin
                            cnt_next = cnt_reg - CW'(1); o_top = rd_top;
                        end
                    end
                    default: ;
                endcase
                if (state_next == sme_pkg::EX_DONE && cnt_next == '0 && !o_fin)
                    o_top = '0;
                if (state_next == sme_pkg::EX_DONE && o_fin && o_st != sme_pkg::ST_OK)
                    o_top = '0;
                o_depth = 9'(cnt_next);
            end
            sme_pkg::EX_MUL: begin
                // product registered in the cycle after operand capture
                if (it_reg != '0) begin
                    wd = sgnsat(neg_reg, (shp[PW-1:NW] != '0) ? {NW{1'b1}} : shp[NW-1:0]);
                    we = 1'b1; wa = AW'(cnt_reg - CW'(2));
                    cnt_next = cnt_reg - CW'(1); o_top = wd; o_depth = 9'(cnt_next);
                    state_next = sme_pkg::EX_DONE;
                end
            end
            sme_pkg::EX_DIV: begin
                if (it_reg == '0) begin
                    wd = sgnsat(neg_reg, quo_reg);
                    we = 1'b1; wa = AW'(cnt_reg - CW'(2));
                    cnt_next = cnt_reg - CW'(1); o_top = wd; o_depth = 9'(cnt_next);
                    state_next = sme_pkg::EX_DONE;
                end
            end
            sme_pkg::EX_DONE: state_next = sme_pkg::EX_IDLE;
            default: state_next = sme_pkg::EX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= sme_pkg::EX_IDLE;
            cnt_reg      <= '0;
            ov_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (res.valid && res.ready) ov_valid_reg <= 1'b0;
            if (state_next == sme_pkg::EX_DONE && state_reg != sme_pkg::EX_DONE)
                ov_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (q_pop) begin
            op_reg   <= q_kind;
            cval_reg <= q_value;
        end
        if (state_next == sme_pkg::EX_DONE && state_reg != sme_pkg::EX_DONE) begin
            ov_top_reg   <= o_top;
            ov_depth_reg <= o_depth;
            ov_fin_reg   <= o_fin;
            ov_st_reg    <= o_st;
        end
        if (state_reg == sme_pkg::EX_CALC) begin
            neg_reg <= rd_sec[VALUE_WIDTH-1] ^ rd_top[VALUE_WIDTH-1];
            ma_reg  <= mag(rd_sec);
            mb_reg  <= mag(rd_top);
            num_reg <= NW'(mag(rd_sec)) << FRAC_BITS;
            rem_reg <= '0;
            quo_reg <= '0;
            it_reg  <= (op_reg == sme_pkg::OP_MUL) ? '0 : IW'(NW);
        end
        else if (state_reg == sme_pkg::EX_MUL) begin
            prod_reg <= PW'(ma_reg) * PW'(mb_reg);
            it_reg   <= IW'(1);
        end
        else if (state_reg == sme_pkg::EX_DIV && it_reg != '0) begin
            // restoring divide, one quotient bit per cycle
            if (rtry >= {1'b0, mb_reg}) begin
                rem_reg <= rtry - {1'b0, mb_reg};
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else begin
                rem_reg <= rtry;
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
            num_reg <= num_reg << 1;
            it_reg  <= it_reg - IW'(1);
        end
    end

    assign res.valid     = ov_valid_reg;
    assign res.top_value = ov_top_reg;
    assign res.depth     = ov_depth_reg;
    assign res.finished  = ov_fin_reg;
    assign res.status    = ov_st_reg;

    property p_depth_bound;
        @(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(STACK_DEPTH);
    endproperty
    assert property (p_depth_bound) else $error("stack count past depth");

    property p_count_step;
        @(posedge clk) disable iff (!rst_n)
            (state_reg != sme_pkg::EX_CALC && state_reg != sme_pkg::EX_MUL &&
             state_reg != sme_pkg::EX_DIV) |=> $stable(cnt_reg);
    endproperty
    assert property (p_count_step) else $error("stack count moved outside execute");

    property p_fin_ret;
        @(posedge clk) disable iff (!rst_n)
            (res.valid && res.finished) |-> (op_reg == sme_pkg::OP_RET);
    endproperty
    assert property (p_fin_ret) else $error("finished without return");
endmodule

>>> sim/sme_tb_checker.sv
// Scoreboard for the stack-machine executor: predicts each result word and compares.
`timescale 1ns / 1ps
module sme_tb_checker (
    input  logic      clk,
    input  logic      rst_n,
    sme_in_if.sink    in,
    sme_out_if.sink   out,
    output int        fail_count,
    output int        pending
);
    localparam int STK = 256;
    localparam logic signed [31:0] VMAX = 32'sh7fffffff;
    localparam logic signed [31:0] VMIN = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [8:0]         depth;
        logic               finished;
        sme_pkg::status_t   status;
    } result_t;

    logic signed [31:0] shadow_stack [STK];
    int                 shadow_count;
    result_t            result_queue [$];

    function automatic logic signed [31:0] clamp(input logic signed [65:0] v);
        if (v > 66'sh0007fffffff)
            return VMAX;
        if (v < -66'sh00080000000)
            return VMIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic [63:0]        ma;
        logic [63:0]        mb;
        logic [127:0]       p;
        logic signed [65:0] r;
        ma = a[31] ? -{{32{a[31]}}, a} : {32'd0, a};
        mb = b[31] ? -{{32{b[31]}}, b} : {32'd0, b};
        p = (ma * mb) >> 16;
        if (p > 128'h80000000)
            p = 128'h80000000 + 1;
        r = (a[31] ^ b[31]) ? -$signed({2'b0, p[63:0]}) : $signed({2'b0, p[63:0]});
        return clamp(r);
    endfunction

    function automatic logic signed [31:0] fx_div(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic [63:0]        ma;
        logic [63:0]        mb;
        logic [63:0]        q;
        logic signed [65:0] r;
        ma = a[31] ? -{{32{a[31]}}, a} : {32'd0, a};
        mb = b[31] ? -{{32{b[31]}}, b} : {32'd0, b};
        q = (ma << 16) / mb;
        if (q > 64'h80000000)
            q = 64'h80000001;
        r = (a[31] ^ b[31]) ? -$signed({2'b0, q}) : $signed({2'b0, q});
        return clamp(r);
    endfunction

    function automatic result_t execute_instruction(input sme_pkg::opcode_t op,
                                                    input logic signed [31:0] cval);
        result_t            res;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] r;
        logic               popped;
        res = '0;
        res.status = sme_pkg::ST_OK;
        popped = 1'b0;
        case (op)
            sme_pkg::OP_PUSH:
                if (shadow_count >= STK)
                    res.status = sme_pkg::ST_OVERFLOW;
                else
                begin
                    shadow_stack[shadow_count] = cval;
                    shadow_count++;
                end
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV:
                if (shadow_count < 2)
                    res.status = sme_pkg::ST_UNDERFLOW;
                else
                begin
                    b = shadow_stack[shadow_count-1];
                    a = shadow_stack[shadow_count-2];
                    case (op)
                        sme_pkg::OP_ADD: r = clamp(66'(a) + 66'(b));
                        sme_pkg::OP_SUB: r = clamp(66'(a) - 66'(b));
                        sme_pkg::OP_MUL: r = fx_mul(a, b);
                        default:
                            if (b == 0)
                            begin
                                r = a[31] ? VMIN : VMAX;
                                res.status = sme_pkg::ST_DIVZERO;
                            end
                            else
                                r = fx_div(a, b);
                    endcase
                    shadow_count--;
                    shadow_stack[shadow_count-1] = r;
                end
            sme_pkg::OP_NEG:
                if (shadow_count < 1)
                    res.status = sme_pkg::ST_UNDERFLOW;
                else
                    shadow_stack[shadow_count-1] = clamp(-66'(shadow_stack[shadow_count-1]));
            sme_pkg::OP_RET:
            begin
                res.finished = 1'b1;
                if (shadow_count < 1)
                    res.status = sme_pkg::ST_UNDERFLOW;
                else
                begin
                    shadow_count--;
                    res.top_value = shadow_stack[shadow_count];
                    popped = 1'b1;
                end
            end
            default: ;
        endcase
        if (!popped)
            res.top_value = shadow_count ? shadow_stack[shadow_count-1] : 32'sd0;
        res.depth = shadow_count[8:0];
        return res;
    endfunction

    assign pending = result_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        result_t got;
        if (!rst_n)
        begin
            shadow_count = 0;
            fail_count <= 0;
            result_queue.delete();
        end
        else
        begin
            if (out.valid && out.ready)
            begin
                got = '{out.top_value, out.depth, out.finished,
                        sme_pkg::status_t'(out.status)};
                if (result_queue.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = result_queue.pop_front();
                    if (got !== exp_r)
                    begin
                        $display("%0t: mismatch expected top=%h depth=%0d fin=%b st=%0d",
                                 $time, exp_r.top_value, exp_r.depth, exp_r.finished,
                                 exp_r.status);
                        $display("%0t:          actual   top=%h depth=%0d fin=%b st=%0d",
                                 $time, got.top_value, got.depth, got.finished, got.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in.valid && in.ready)
                result_queue.push_back(execute_instruction(sme_pkg::opcode_t'(in.kind),
                                                           in.constant_value));
        end
    end
endmodule

>>> sim/tb_stack_machine_arith_executor.sv
// Testbench top: stimulus, output back-pressure and verdict for the stack-machine executor.
`timescale 1ns / 1ps
module tb_stack_machine_arith_executor;
    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   model_depth;
    bit   hold_off;

    sme_in_if  #(.VALUE_WIDTH(32)) in_ch ();
    sme_out_if #(.VALUE_WIDTH(32)) out_ch ();

    stack_machine_arith_executor u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    sme_tb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in         (in_ch.sink),
        .out        (out_ch.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_stack_machine_arith_executor failed");
        $finish;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            4: return {{16{1'b0}}, 16'($urandom)};
            5: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)} ;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input sme_pkg::opcode_t op, input logic [31:0] val);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.kind           <= op;
        in_ch.constant_value <= val;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        // track stack depth for shaping the random mix
        case (op)
            sme_pkg::OP_PUSH: if (model_depth < 256) model_depth++;
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV:
                if (model_depth >= 2) model_depth--;
            sme_pkg::OP_RET: if (model_depth >= 1) model_depth--;
            default: ;
        endcase
    endtask

    // output back-pressure, with one long stall in the middle of the run
    initial
    begin
        int wait_n;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_n = $urandom_range(0, 3);
            if (wait_n != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    initial
    begin
        int               n;
        int               k;
        sme_pkg::opcode_t op;
        in_ch.valid          <= 1'b0;
        in_ch.kind           <= sme_pkg::OP_NOP;
        in_ch.constant_value <= '0;
        rst_n                 = 1'b0;
        model_depth           = 0;
        hold_off              = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-stack underflows, extremes, divide by zero, saturation
        send_word(sme_pkg::OP_ADD, 0);
        send_word(sme_pkg::OP_NEG, 0);
        send_word(sme_pkg::OP_RET, 0);
        send_word(sme_pkg::OP_NOP, 32'hffffffff);
        send_word(sme_pkg::OP_PUSH, 32'h80000000);
        send_word(sme_pkg::OP_DIV, 0);
        send_word(sme_pkg::OP_NEG, 0);
        send_word(sme_pkg::OP_PUSH, 32'h7fffffff);
        send_word(sme_pkg::OP_ADD, 0);
        send_word(sme_pkg::OP_PUSH, 32'h80000000);
        send_word(sme_pkg::OP_SUB, 0);
        send_word(sme_pkg::OP_PUSH, 32'h80000000);
        send_word(sme_pkg::OP_MUL, 0);
        send_word(sme_pkg::OP_PUSH, 32'h0);
        send_word(sme_pkg::OP_DIV, 0);
        send_word(sme_pkg::OP_PUSH, 32'h80000000);
        send_word(sme_pkg::OP_PUSH, 32'h0);
        send_word(sme_pkg::OP_DIV, 0);
        send_word(sme_pkg::OP_PUSH, 32'h00000001);
        send_word(sme_pkg::OP_DIV, 0);
        send_word(sme_pkg::OP_PUSH, 32'hfffe8000);
        send_word(sme_pkg::OP_MUL, 0);
        send_word(sme_pkg::OP_RET, 0);
        send_word(sme_pkg::OP_RET, 0);
        send_word(sme_pkg::OP_RET, 0);

        // fill to overflow
        for (k = 0; k < 258; k++)
            send_word(sme_pkg::OP_PUSH, pick_value());
        for (k = 0; k < 256; k++)
        begin
            op = sme_pkg::opcode_t'($urandom_range(1, 6));
            send_word(op, 0);
        end

        // random mix biased by depth; long output stall partway through
        for (n = 0; n < 410; n++)
        begin
            if (n == 300)
                hold_off = 1'b1;
            k = $urandom_range(0, 99);
            if (k < 4)
                op = sme_pkg::opcode_t'($urandom_range(0, 7));
            else if (model_depth < 2 || (k < 45 && model_depth < 250))
                op = sme_pkg::OP_PUSH;
            else
                op = sme_pkg::opcode_t'($urandom_range(1, 6));
            send_word(op, pick_value());
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_stack_machine_arith_executor passed");
        else
            $display("tb_stack_machine_arith_executor failed");
        $finish;
    end
endmodule
